// ----- sv/dccd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dccd_pkg: shared types and constants of the day count to date unit
// Operation codes of the shared divider, its constant tables, the month
// length table and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package dccd_pkg;

   // field widths fixed by the interface
   localparam int DAY_W   = 24;
   localparam int MS_W    = 27;
   localparam int YEAR_W  = 16;
   localparam int REM_W   = MS_W;
   localparam int QUO_W   = 15;
   localparam int REC_W   = 25;
   localparam int PROD_W  = REM_W + REC_W;

   // reciprocal scale; every dividend stays below 2^RECIP_SHIFT
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP_ONE   = 1 << RECIP_SHIFT;

   // divisors of the operations
   localparam int DIV_C400 = 146097;
   localparam int DIV_WDAY = 7;
   localparam int DIV_C100 = 36524;
   localparam int DIV_C4   = 1461;
   localparam int DIV_C1   = 365;
   localparam int DIV_HOUR = 1000 * 60 * 60;
   localparam int DIV_MIN  = 60000;
   localparam int DIV_SEC  = 1000;

   // calendar and clock constants
   localparam logic [MS_W-1:0]   MS_IN_DAY          = MS_W'(86400000);
   localparam logic [MS_W-1:0]   MS_IN_SECOND       = MS_W'(1000);
   localparam int                DAYS_BASE_TO_1980  = 138426;
   localparam logic [YEAR_W-1:0] BASE_YEAR          = YEAR_W'(1601);
   localparam int                DAYS_IN_LEAP_YEAR  = 366;
   localparam logic [4:0]        FEB_DAYS_LEAP      = 5'd29;
   localparam logic [3:0]        FEB_IDX            = 4'd1;
   localparam logic [3:0]        DEC_IDX            = 4'd11;
   localparam logic [4:0]        C4_LAST_OF_CENTURY = 5'd24;
   localparam logic [1:0]        CYCLE_CLAMP        = 2'd3;

   localparam logic [4:0] MONTH_DAYS [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // divider operations, in the order the controller runs them
   localparam logic [2:0] OP_C400 = 3'd0;   // 400-year cycles
   localparam logic [2:0] OP_WDAY = 3'd1;   // weekday, mod 7
   localparam logic [2:0] OP_C100 = 3'd2;   // 100-year cycles, clamped to 3
   localparam logic [2:0] OP_C4   = 3'd3;   // 4-year cycles
   localparam logic [2:0] OP_C1   = 3'd4;   // single years, clamped to 3
   localparam logic [2:0] OP_HOUR = 3'd5;
   localparam logic [2:0] OP_MIN  = 3'd6;
   localparam logic [2:0] OP_SEC  = 3'd7;

   typedef struct packed {
      logic       capture;   // take a new input beat
      logic       load;      // load the dividend for op
      logic       mul;       // multiply by the scaled reciprocal
      logic       est;       // form the quotient estimate and its remainder
      logic       fix;       // raise an estimate that came out one low
      logic       store;     // write back quotient and remainder of op
      logic       month;     // one month walk step
      logic       publish;   // move results to the output registers
      logic [2:0] op;
   } dccd_cmd_type;

   typedef struct packed {
      logic month_last;      // day of year falls in the current month, or the month is December
   } dccd_status_type;

   // divisor of each operation
   function automatic logic [REM_W-1:0] op_base(input logic [2:0] op);
      logic [REM_W-1:0] b;
      unique case (op)
         OP_C400: b = REM_W'(DIV_C400);
         OP_WDAY: b = REM_W'(DIV_WDAY);
         OP_C100: b = REM_W'(DIV_C100);
         OP_C4:   b = REM_W'(DIV_C4);
         OP_C1:   b = REM_W'(DIV_C1);
         OP_HOUR: b = REM_W'(DIV_HOUR);
         OP_MIN:  b = REM_W'(DIV_MIN);
         OP_SEC:  b = REM_W'(DIV_SEC);
         default: b = REM_W'(1);
      endcase
      return b;
   endfunction

   // floor(2^RECIP_SHIFT / divisor); the quotient it gives is low by at most one
   function automatic logic [REC_W-1:0] op_recip(input logic [2:0] op);
      logic [REC_W-1:0] r;
      unique case (op)
         OP_C400: r = REC_W'(RECIP_ONE / DIV_C400);
         OP_WDAY: r = REC_W'(RECIP_ONE / DIV_WDAY);
         OP_C100: r = REC_W'(RECIP_ONE / DIV_C100);
         OP_C4:   r = REC_W'(RECIP_ONE / DIV_C4);
         OP_C1:   r = REC_W'(RECIP_ONE / DIV_C1);
         OP_HOUR: r = REC_W'(RECIP_ONE / DIV_HOUR);
         OP_MIN:  r = REC_W'(RECIP_ONE / DIV_MIN);
         OP_SEC:  r = REC_W'(RECIP_ONE / DIV_SEC);
         default: r = '0;
      endcase
      return r;
   endfunction

   // years per cycle counted by the operation
   function automatic logic [8:0] op_year_weight(input logic [2:0] op);
      logic [8:0] w;
      unique case (op)
         OP_C400: w = 9'd400;
         OP_C100: w = 9'd100;
         OP_C4:   w = 9'd4;
         OP_C1:   w = 9'd1;
         default: w = 9'd0;
      endcase
      return w;
   endfunction

   // the last century of a 400-year run or the last year of a 4-year run is one day longer
   function automatic logic op_clamps(input logic [2:0] op);
      return (op == OP_C100) || (op == OP_C1);
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
      logic [4:0] n;
      if (mon == FEB_IDX && leap) begin
         n = FEB_DAYS_LEAP;
      end else begin
         n = MONTH_DAYS[mon];
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ----- sv/dccd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dccd_ctrl: sequencer of the day count to date unit
// Walks the divider through its operations, runs the month walk, and owns
// the handshake of both channels.
// ----------------------------------------------------------------------------
module dccd_ctrl
   import dccd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output dccd_cmd_type         cmd,
   input  wire dccd_status_type status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_EST   = 3'd3;
   localparam logic [2:0] S_FIX   = 3'd4;
   localparam logic [2:0] S_STORE = 3'd5;
   localparam logic [2:0] S_MONTH = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // take beats only between items, never in reset
   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequence the operations
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = OP_C400;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_EST;
         end
         S_EST: begin
            cmd.est  = 1'b1;
            state_in = S_FIX;
         end
         S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = S_STORE;
         end
         S_STORE: begin
            cmd.store = 1'b1;
            if (op_ff == OP_C1) begin
               state_in = S_MONTH;
            end else if (op_ff == OP_SEC) begin
               state_in = S_DONE;
            end else begin
               op_in    = op_ff + 3'd1;
               state_in = S_LOAD;
            end
         end
         S_MONTH: begin
            cmd.month = 1'b1;
            if (status.month_last) begin
               op_in    = OP_HOUR;
               state_in = S_LOAD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold the result beat until taken
   assign rsp_valid_in = cmd.publish | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_C400;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_publish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("result not shown after publish");

   a_load_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_MUL))
      else $error("divider load not followed by the multiply");

   a_fix_stores: assert property (@(posedge clock) disable iff (reset)
      cmd.fix |=> cmd.store)
      else $error("corrected quotient not written back");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request taken while busy");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_LOAD && op_ff == OP_C400))
      else $error("accepted beat did not start the 400-year split");

endmodule
`default_nettype wire

// ----- sv/dccd_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dccd_dpath: datapath of the day count to date unit
// Holds the working day and millisecond values, a shared reciprocal divider
// by constants, the year accumulator, the month walk and the result registers.
// ----------------------------------------------------------------------------
module dccd_dpath
   import dccd_pkg::*;
#(
   parameter int DAY_COUNT_BITS = 24
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dccd_cmd_type      cmd,
   output dccd_status_type        status,
   input  wire logic [DAY_W-1:0]  req_day_count,
   input  wire logic [MS_W-1:0]   req_ms_of_day,
   output logic [2:0]             rsp_weekday,
   output logic [YEAR_W-1:0]      rsp_year,
   output logic [3:0]             rsp_month,
   output logic [4:0]             rsp_day_of_month,
   output logic [4:0]             rsp_hours,
   output logic [5:0]             rsp_minutes,
   output logic [5:0]             rsp_seconds,
   output logic [9:0]             rsp_millis
);

   // days since 1 January 1601, including one folded day
   localparam int DATE_W = ((DAY_COUNT_BITS > 18) ? DAY_COUNT_BITS : 18) + 1;
   localparam int QB_W   = QUO_W + REM_W;

   logic [DATE_W-1:0] date_ff, date_in;
   logic [MS_W-1:0]   ms_ff, ms_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [YEAR_W-1:0] year_ff, year_in;
   logic [3:0]        mon_ff, mon_in;
   logic [1:0]        c100_ff, c100_in;
   logic [4:0]        c4_ff, c4_in;
   logic [1:0]        c1_ff, c1_in;
   logic [2:0]        wday_ff, wday_in;
   logic [4:0]        hours_ff, hours_in;
   logic [5:0]        minutes_ff, minutes_in;
   logic [5:0]        seconds_ff, seconds_in;

   logic [2:0]        rsp_weekday_ff;
   logic [YEAR_W-1:0] rsp_year_ff;
   logic [3:0]        rsp_month_ff;
   logic [4:0]        rsp_day_of_month_ff;
   logic [4:0]        rsp_hours_ff;
   logic [5:0]        rsp_minutes_ff;
   logic [5:0]        rsp_seconds_ff;
   logic [9:0]        rsp_millis_ff;

   logic              fold;
   logic [DATE_W-1:0] days_masked;
   logic [REM_W-1:0]  base;
   logic [QUO_W-1:0]  q_est;
   logic [QB_W-1:0]   qb;
   logic              clamp;
   logic [QUO_W-1:0]  quo_c;
   logic [REM_W-1:0]  rem_c;
   logic              leap;
   logic [4:0]        mlen;

   // fold a whole day out of the milliseconds
   assign fold        = (req_ms_of_day >= MS_IN_DAY);
   assign days_masked = DATE_W'(req_day_count[DAY_COUNT_BITS-1:0]);

   // quotient estimate from the scaled product, and its multiple of the divisor
   assign base  = op_base(cmd.op);
   assign q_est = prod_ff[RECIP_SHIFT +: QUO_W];
   assign qb    = QB_W'(q_est) * QB_W'(base);

   // clamp the last century or year of a run to cycle 3
   assign clamp = op_clamps(cmd.op) && quo_ff[2];
   assign quo_c = clamp ? QUO_W'(CYCLE_CLAMP) : quo_ff;
   assign rem_c = clamp ? base : rem_ff;

   // leap year from the cycle counts: year 4k, but not a century unless 400k
   assign leap = (c1_ff == CYCLE_CLAMP) &&
                 ((c4_ff != C4_LAST_OF_CENTURY) || (c100_ff == CYCLE_CLAMP));
   assign mlen = month_len(mon_ff, leap);
   assign status.month_last = (date_ff < DATE_W'(mlen)) || (mon_ff == DEC_IDX);

   always_comb begin
      date_in    = date_ff;
      ms_in      = ms_ff;
      rem_in     = rem_ff;
      prod_in    = prod_ff;
      quo_in     = quo_ff;
      year_in    = year_ff;
      mon_in     = mon_ff;
      c100_in    = c100_ff;
      c4_in      = c4_ff;
      c1_in      = c1_ff;
      wday_in    = wday_ff;
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;

      // capture a new beat
      if (cmd.capture) begin
         ms_in   = fold ? (req_ms_of_day - MS_IN_DAY) : req_ms_of_day;
         date_in = days_masked + DATE_W'(DAYS_BASE_TO_1980) + DATE_W'(fold);
         year_in = BASE_YEAR;
         mon_in  = '0;
      end

      // load the divider from the value the op works on
      if (cmd.load) begin
         quo_in = '0;
         case (cmd.op) inside
            OP_WDAY:                 rem_in = REM_W'(date_ff) + REM_W'(1);
            OP_HOUR, OP_MIN, OP_SEC: rem_in = REM_W'(ms_ff);
            default:                 rem_in = REM_W'(date_ff);
         endcase
      end

      // multiply the dividend by the scaled reciprocal
      if (cmd.mul) begin
         prod_in = PROD_W'(rem_ff) * PROD_W'(op_recip(cmd.op));
      end

      // take the estimate; its remainder is below twice the divisor
      if (cmd.est) begin
         quo_in = q_est;
         rem_in = rem_ff - qb[REM_W-1:0];
      end

      // raise an estimate that came out one low
      if (cmd.fix && (rem_ff >= base)) begin
         quo_in = quo_ff + QUO_W'(1);
         rem_in = rem_ff - base;
      end

      // write back quotient and remainder
      if (cmd.store) begin
         year_in = year_ff + YEAR_W'(quo_c[6:0]) * YEAR_W'(op_year_weight(cmd.op));
         case (cmd.op)
            OP_C400: date_in = rem_c[DATE_W-1:0];
            OP_WDAY: wday_in = rem_c[2:0];
            OP_C100: begin
               date_in = rem_c[DATE_W-1:0];
               c100_in = quo_c[1:0];
            end
            OP_C4: begin
               date_in = rem_c[DATE_W-1:0];
               c4_in   = quo_c[4:0];
            end
            OP_C1: begin
               date_in = rem_c[DATE_W-1:0];
               c1_in   = quo_c[1:0];
            end
            OP_HOUR: begin
               ms_in    = rem_c;
               hours_in = quo_c[4:0];
            end
            OP_MIN: begin
               ms_in      = rem_c;
               minutes_in = quo_c[5:0];
            end
            OP_SEC: begin
               ms_in      = rem_c;
               seconds_in = quo_c[5:0];
            end
            default: begin
               date_in = date_ff;
            end
         endcase
      end

      // walk the months of the year
      if (cmd.month && !status.month_last) begin
         date_in = date_ff - DATE_W'(mlen);
         mon_in  = mon_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      date_ff    <= date_in;
      ms_ff      <= ms_in;
      rem_ff     <= rem_in;
      prod_ff    <= prod_in;
      quo_ff     <= quo_in;
      year_ff    <= year_in;
      mon_ff     <= mon_in;
      c100_ff    <= c100_in;
      c4_ff      <= c4_in;
      c1_ff      <= c1_in;
      wday_ff    <= wday_in;
      hours_ff   <= hours_in;
      minutes_ff <= minutes_in;
      seconds_ff <= seconds_in;
   end

   // load the result beat
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_weekday_ff      <= wday_ff;
         rsp_year_ff         <= year_ff;
         rsp_month_ff        <= mon_ff + 4'd1;
         rsp_day_of_month_ff <= date_ff[4:0] + 5'd1;
         rsp_hours_ff        <= hours_ff;
         rsp_minutes_ff      <= minutes_ff;
         rsp_seconds_ff      <= seconds_ff;
         rsp_millis_ff       <= ms_ff[9:0];
      end
   end

   assign rsp_weekday      = rsp_weekday_ff;
   assign rsp_year         = rsp_year_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_day_of_month = rsp_day_of_month_ff;
   assign rsp_hours        = rsp_hours_ff;
   assign rsp_minutes      = rsp_minutes_ff;
   assign rsp_seconds      = rsp_seconds_ff;
   assign rsp_millis       = rsp_millis_ff;

   a_day_of_year: assert property (@(posedge clock) disable iff (reset)
      cmd.month |-> (date_ff < DATE_W'(DAYS_IN_LEAP_YEAR)))
      else $error("day of year out of range during month walk");

   a_estimate_close: assert property (@(posedge clock) disable iff (reset)
      cmd.fix |-> ({1'b0, rem_ff} < {base, 1'b0}))
      else $error("quotient estimate more than one low");

   a_weekday_rem: assert property (@(posedge clock) disable iff (reset)
      (cmd.store && cmd.op == OP_WDAY) |-> (rem_ff < REM_W'(7)))
      else $error("weekday remainder not reduced");

   a_millis_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (ms_ff < MS_IN_SECOND))
      else $error("millisecond remainder not reduced");

endmodule
`default_nettype wire

// ----- sv/day_count_to_calendar_date_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// day_count_to_calendar_date_unit: day count and milliseconds to date and time
// Converts days since 1 January 1980 plus milliseconds of the day into
// weekday, Gregorian year, month, day, hours, minutes, seconds and millis.
// ----------------------------------------------------------------------------
// Usage: the unit works on one beat at a time and accepts the next request
// beat only once it has published the last result; req_stall is high while
// it works and during reset. The work is eight divisions by constants on one
// shared unit, each in the steps load, multiply by a scaled reciprocal,
// estimate, correct by one and write back: the 400-, 100-, 4- and 1-year
// splits, the weekday and the hour, minute and second splits, plus a month
// walk of one month a cycle. A finished result sits in its own register, so
// a new request is taken while the result beat still waits on rsp_stall;
// the next finished result then waits until that beat is taken.
// Milliseconds of a whole day or more carry one day into the day count.
// Only the low DAY_COUNT_BITS bits of the day count are used.
module day_count_to_calendar_date_unit
   import dccd_pkg::*;
#(
   parameter int DAY_COUNT_BITS = 24
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [DAY_W-1:0]  req_day_count,
   input  wire logic [MS_W-1:0]   req_ms_of_day,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_weekday,
   output logic [YEAR_W-1:0]      rsp_year,
   output logic [3:0]             rsp_month,
   output logic [4:0]             rsp_day_of_month,
   output logic [4:0]             rsp_hours,
   output logic [5:0]             rsp_minutes,
   output logic [5:0]             rsp_seconds,
   output logic [9:0]             rsp_millis
);

   dccd_cmd_type    cmd;
   dccd_status_type status;

   // sequence the conversion
   dccd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // divide, accumulate and hold results
   dccd_dpath #(
      .DAY_COUNT_BITS (DAY_COUNT_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_day_count    (req_day_count),
      .req_ms_of_day    (req_ms_of_day),
      .rsp_weekday      (rsp_weekday),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hours        (rsp_hours),
      .rsp_minutes      (rsp_minutes),
      .rsp_seconds      (rsp_seconds),
      .rsp_millis       (rsp_millis)
   );

endmodule
`default_nettype wire

// ----- tb/tb_day_count_to_calendar_date_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_day_count_to_calendar_date_unit: self-checking bench of the date unit
// Offers timestamps (day count plus milliseconds of the day), predicts the
// weekday, date and time of day of each one and checks every result beat in
// order. Covers calendar edges, carried days, random traffic, back-to-back
// beats and a long output hold-off that fills the unit.
// ----------------------------------------------------------------------------
module tb_day_count_to_calendar_date_unit;
   import dccd_pkg::DAY_W;
   import dccd_pkg::MS_W;
   import dccd_pkg::YEAR_W;

   localparam int          DAY_BITS        = 24;
   localparam int unsigned DAY_MS          = 86400000;
   localparam int unsigned HOUR_MS         = 1000 * 60 * 60;
   localparam int unsigned MINUTE_MS       = 60000;
   localparam int unsigned SECOND_MS       = 1000;
   localparam int unsigned FIRST_YEAR      = 1601;
   localparam int unsigned DAYS_TO_1980    = 138426;
   localparam int unsigned DAYS_PER_400Y   = 146097;
   localparam int unsigned DAYS_PER_100Y   = 36524;
   localparam int unsigned DAYS_PER_4Y     = 1461;
   localparam int unsigned DAYS_PER_YEAR   = 365;
   localparam int unsigned MS_FIELD_MAX    = (1 << MS_W) - 1;
   localparam int unsigned DAY_FIELD_MAX   = (1 << DAY_W) - 1;
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam int          DRAIN_CYCLES    = 100;

   localparam int unsigned MONTH_LENGTH [12] = '{
      31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
   };

   typedef struct packed {
      logic [2:0]        weekday;
      logic [YEAR_W-1:0] year;
      logic [3:0]        month;
      logic [4:0]        mday;
      logic [4:0]        hours;
      logic [5:0]        minutes;
      logic [5:0]        seconds;
      logic [9:0]        millis;
   } calendar_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [DAY_W-1:0]  req_day_count = '0;
   logic [MS_W-1:0]   req_ms_of_day = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_weekday;
   logic [YEAR_W-1:0] rsp_year;
   logic [3:0]        rsp_month;
   logic [4:0]        rsp_day_of_month;
   logic [4:0]        rsp_hours;
   logic [5:0]        rsp_minutes;
   logic [5:0]        rsp_seconds;
   logic [9:0]        rsp_millis;

   calendar_t expected_dates [$];
   logic      idle_on = 1'b1;
   int        hold_requests = 0;
   int        hold_served = 0;
   int        hold_left = 0;
   int        stall_left = 0;
   int        error_count = 0;
   int        dates_checked = 0;
   int        carried_days = 0;
   int        leap_days = 0;
   int        century_items = 0;

   day_count_to_calendar_date_unit #(
      .DAY_COUNT_BITS(DAY_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_day_count   (req_day_count),
      .req_ms_of_day   (req_ms_of_day),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_weekday     (rsp_weekday),
      .rsp_year        (rsp_year),
      .rsp_month       (rsp_month),
      .rsp_day_of_month(rsp_day_of_month),
      .rsp_hours       (rsp_hours),
      .rsp_minutes     (rsp_minutes),
      .rsp_seconds     (rsp_seconds),
      .rsp_millis      (rsp_millis)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Split a timestamp into weekday, Gregorian date and time of day.
   function automatic calendar_t to_calendar(input logic [DAY_W-1:0] day_in,
                                             input logic [MS_W-1:0] ms_in);
      int unsigned days;
      int unsigned ms;
      int unsigned rest;
      int unsigned n400;
      int unsigned n100;
      int unsigned n4;
      int unsigned n1;
      int unsigned yr;
      int unsigned mon;
      int unsigned mlen;
      logic        leap;
      logic        found;
      calendar_t   r;
      days = 32'(day_in) & ((32'd1 << DAY_BITS) - 1);
      ms   = 32'(ms_in);
      // carry a whole day out of the milliseconds
      if (ms >= DAY_MS) begin
         ms   = ms - DAY_MS;
         days = days + 1;
      end
      r.weekday = 3'((days + 2) % 7);
      // peel off 400-, 100-, 4- and 1-year cycles counted from 1601
      rest = days + DAYS_TO_1980;
      n400 = rest / DAYS_PER_400Y;
      rest = rest - n400 * DAYS_PER_400Y;
      n100 = rest / DAYS_PER_100Y;
      if (n100 > 3) n100 = 3;
      rest = rest - n100 * DAYS_PER_100Y;
      n4   = rest / DAYS_PER_4Y;
      rest = rest - n4 * DAYS_PER_4Y;
      n1   = rest / DAYS_PER_YEAR;
      if (n1 > 3) n1 = 3;
      rest = rest - n1 * DAYS_PER_YEAR;
      yr   = FIRST_YEAR + 400 * n400 + 100 * n100 + 4 * n4 + n1;
      leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      // walk the months; December takes whatever is left
      mon   = 0;
      found = 1'b0;
      while (mon < 11 && !found) begin
         mlen = (mon == 1 && leap) ? 29 : MONTH_LENGTH[mon];
         if (rest < mlen) begin
            found = 1'b1;
         end else begin
            rest = rest - mlen;
            mon  = mon + 1;
         end
      end
      r.year    = YEAR_W'(yr);
      r.month   = 4'(mon + 1);
      r.mday    = 5'(rest + 1);
      r.hours   = 5'(ms / HOUR_MS);
      r.minutes = 6'((ms / MINUTE_MS) % 60);
      r.seconds = 6'((ms / SECOND_MS) % 60);
      r.millis  = 10'(ms % SECOND_MS);
      return r;
   endfunction

   // Offer one timestamp beat, hold it until taken, then log its prediction.
   task automatic send_timestamp(input logic [DAY_W-1:0] day,
                                 input logic [MS_W-1:0] ms);
      int        gap;
      calendar_t predicted;
      if (idle_on && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         gap = ($urandom_range(7) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_day_count <= day;
      req_ms_of_day <= ms;
      do @(posedge clock); while (req_stall);
      predicted = to_calendar(day, ms);
      expected_dates.push_back(predicted);
      if (32'(ms) >= DAY_MS) carried_days++;
      if (predicted.month == 4'd2 && predicted.mday == 5'd29) leap_days++;
      if (predicted.year % 100 == 0) century_items++;
   endtask

   // Drop valid and wait until every predicted date has come back.
   task automatic wait_for_dates();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_dates.size() != 0);
   endtask

   task automatic pick_timestamp(output logic [DAY_W-1:0] day, output logic [MS_W-1:0] ms);
      day = DAY_W'($urandom());
      ms  = MS_W'($urandom_range(DAY_MS - 1));
      case ($urandom_range(9))
         5: day = DAY_W'($urandom_range(60000));
         6: day = DAY_W'(DAY_FIELD_MAX - $urandom_range(1000));
         7: ms  = ($urandom_range(1) == 0) ? MS_W'(DAY_MS - 1 - $urandom_range(2000))
                                           : MS_W'($urandom_range(5000));
         8: ms  = MS_W'($urandom_range(MS_FIELD_MAX, DAY_MS));
         9: ms  = MS_W'($urandom());
         default: ;
      endcase
   endtask

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Check result beats and drive rsp_stall, one assignment per edge.
   always @(posedge clock) begin
      calendar_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_dates.size() == 0) begin
            $display("%0t: result beat with no date expected, year %0d month %0d day %0d",
                     $time, rsp_year, rsp_month, rsp_day_of_month);
            error_count++;
         end else begin
            want = expected_dates.pop_front();
            report_field("weekday", want.weekday, rsp_weekday);
            report_field("year", want.year, rsp_year);
            report_field("month", want.month, rsp_month);
            report_field("day_of_month", want.mday, rsp_day_of_month);
            report_field("hours", want.hours, rsp_hours);
            report_field("minutes", want.minutes, rsp_minutes);
            report_field("seconds", want.seconds, rsp_seconds);
            report_field("millis", want.millis, rsp_millis);
            dates_checked++;
         end
      end
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(99) < 3) begin
         stall_left = $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Calendar and clock edges, every weekday and the carried-day cases.
   task automatic test_directed_dates();
      int unsigned day_list [23] = '{
         0, 0, 1, 2, 3, 4, 5, 6, 59, 60, 365, 366, 7304, 7364, 43888, 43889,
         DAY_FIELD_MAX, DAY_FIELD_MAX, 0, 5, DAY_FIELD_MAX, 24'hAAAAAA, 24'h555555
      };
      int unsigned ms_list [23] = '{
         0, DAY_MS - 1, HOUR_MS - 1, HOUR_MS, MINUTE_MS - 1, MINUTE_MS,
         SECOND_MS - 1, SECOND_MS, 43200000, 0, 0, 0, DAY_MS - 1, 0, 0, 0,
         0, DAY_MS - 1, DAY_MS, MS_FIELD_MAX, MS_FIELD_MAX, 27'h5555555, 27'h2AAAAAA
      };
      foreach (day_list[i]) send_timestamp(DAY_W'(day_list[i]), MS_W'(ms_list[i]));
      wait_for_dates();
   endtask

   task automatic test_random_timestamps(input int count);
      logic [DAY_W-1:0] day;
      logic [MS_W-1:0]  ms;
      repeat (count) begin
         pick_timestamp(day, ms);
         send_timestamp(day, ms);
      end
      wait_for_dates();
   endtask

   // Back-to-back beats with no idling on either side.
   task automatic test_back_to_back(input int count);
      logic [DAY_W-1:0] day;
      logic [MS_W-1:0]  ms;
      idle_on <= 1'b0;
      repeat (count) begin
         pick_timestamp(day, ms);
         send_timestamp(day, ms);
      end
      wait_for_dates();
      idle_on <= 1'b1;
   endtask

   // Hold the output off while beats keep coming, so the unit fills and stalls.
   task automatic test_output_hold_off();
      logic [DAY_W-1:0] day;
      logic [MS_W-1:0]  ms;
      hold_requests <= hold_requests + 1;
      repeat (8) begin
         pick_timestamp(day, ms);
         send_timestamp(day, ms);
      end
      wait_for_dates();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_dates();
      test_random_timestamps(600);
      test_back_to_back(200);
      test_output_hold_off();
      test_random_timestamps(570);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d dates: %0d with a carried day, %0d on 29 February, %0d in century years,",
               dates_checked, carried_days, leap_days, century_items);
      $display("with random idling, a back-to-back stretch and a %0d-cycle output hold-off.",
               HOLD_OFF_CYCLES);
      if (error_count == 0 && expected_dates.size() == 0) begin
         $display("day_count_to_calendar_date_unit test passed");
      end else begin
         $display("day_count_to_calendar_date_unit test failed");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("%0t: timeout with %0d dates outstanding", $time, expected_dates.size());
      $display("day_count_to_calendar_date_unit test failed");
      $finish;
   end

endmodule
